[hdl/cross_linked_dual_parallel_port_defines.svh]
// ----------------------------------------------------------------------------
// cross_linked_dual_parallel_port_defines.svh
// Assertion macros used by the sequencer of the parallel port pair.
// ----------------------------------------------------------------------------
`ifndef CROSS_LINKED_DUAL_PARALLEL_PORT_DEFINES_SVH
`define CROSS_LINKED_DUAL_PARALLEL_PORT_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define CLPP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle
`define CLPP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/clpp_pkg.sv]
// ----------------------------------------------------------------------------
// clpp_pkg
// Shared codes, reset patterns and command type of the parallel port pair.
// ----------------------------------------------------------------------------
package clpp_pkg;

	// Access codes
	localparam logic [2:0] MODE_RD_AB  = 3'd0;
	localparam logic [2:0] MODE_WR_AB  = 3'd1;
	localparam logic [2:0] MODE_RD_C   = 3'd2;
	localparam logic [2:0] MODE_BIT_C  = 3'd3;
	localparam logic [2:0] MODE_WR_C   = 3'd4;
	localparam logic [2:0] MODE_SET    = 3'd5;

	// Switching policy codes; every negative code acts as switch
	localparam logic signed [2:0] POL_PLAIN = 3'sd0;
	localparam logic signed [2:0] POL_WAKE  = 3'sd1;
	localparam logic signed [2:0] POL_BOTH  = 3'sd2;
	localparam logic signed [2:0] POL_WAIT  = 3'sd3;

	// Dual-run load codes
	localparam logic [1:0] BOTH_NONE = 2'd0;
	localparam logic [1:0] BOTH_STD  = 2'd1;
	localparam logic [1:0] BOTH_ONE  = 2'd2;

	// Port C half select
	localparam logic HALF_HI = 1'b0;
	localparam logic HALF_LO = 1'b1;

	// Entry count of the per-port state, indexed {side, port}
	localparam int NUM_ENTRIES = 4;

	// Direction after reset: A input, B output; C high output, C low input
	localparam logic [NUM_ENTRIES-1:0] AB_IN_RST = 4'b0101;
	localparam logic [NUM_ENTRIES-1:0] C_IN_RST  = 4'b1010;

	typedef struct packed {
		logic load;
		logic exec;
	} clpp_cmd_t;

endpackage

[hdl/clpp_if.sv]
// ----------------------------------------------------------------------------
// clpp_if
// Access and result channels of the parallel port pair.
// ----------------------------------------------------------------------------
interface clpp_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic       side;
	logic       port_sel;
	logic [7:0] wdata;

	modport source (output valid, output mode, output side, output port_sel,
		output wdata, input ready);
	modport sink (input valid, input mode, input side, input port_sel,
		input wdata, output ready);
endinterface

interface clpp_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       toggle_cpu;
	logic       stop_running;
	logic       main_dormant;
	logic       sub_dormant;
	logic [1:0] run_both_code;
	logic       mismatch;

	modport source (output valid, output read_data, output toggle_cpu,
		output stop_running, output main_dormant, output sub_dormant,
		output run_both_code, output mismatch, input ready);
	modport sink (input valid, input read_data, input toggle_cpu,
		input stop_running, input main_dormant, input sub_dormant,
		input run_both_code, input mismatch, output ready);
endinterface

[hdl/clpp_ctrl.sv]
// ----------------------------------------------------------------------------
// clpp_ctrl
// Sequencer: captures one access word, runs it, and holds the result word.
// ----------------------------------------------------------------------------
`include "cross_linked_dual_parallel_port_defines.svh"

module clpp_ctrl
	import clpp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output clpp_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;

	// Take a word only when no access is in flight
	assign in_ready  = (state_q == ST_IDLE);
	assign cmd.load  = in_valid && in_ready;
	// Run the access once the result slot is free or being emptied
	assign cmd.exec  = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.exec) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	`CLPP_ASSERT_NEXT(ast_load_runs, cmd.load, state_q == ST_EXEC, "load did not start run")
	`CLPP_ASSERT_NEXT(ast_exec_shows, cmd.exec, out_valid_q, "result word not shown")
	`CLPP_ASSERT_SAME(ast_no_overwrite, out_valid_q && !out_ready, !cmd.exec,
		"result word overwritten")

endmodule

[hdl/clpp_dp.sv]
// ----------------------------------------------------------------------------
// clpp_dp
// Port state of both units, access decode and result register.
// ----------------------------------------------------------------------------
module clpp_dp
	import clpp_pkg::*;
#(
	parameter int RETRY_COUNT = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  clpp_cmd_t         cmd,
	input  logic              cfg_we,
	input  logic signed [2:0] cfg_wdata,
	input  logic [2:0]        mode,
	input  logic              side,
	input  logic              port_sel,
	input  logic [7:0]        wdata,
	output logic [7:0]        read_data,
	output logic              toggle_cpu,
	output logic              stop_running,
	output logic              main_dormant,
	output logic              sub_dormant,
	output logic [1:0]        run_both_code,
	output logic              mismatch
);

	localparam logic [4:0] RETRY_RLD = 5'(RETRY_COUNT);

	// Policy register
	logic signed [2:0] policy_q;

	// Captured access word
	logic [2:0] mode_q;
	logic       side_q;
	logic       port_q;
	logic [7:0] wdata_q;

	// Port state, indexed {side, port} or {side, half}
	logic [NUM_ENTRIES-1:0] ab_in_q, ab_in_d;
	logic [NUM_ENTRIES-1:0] ab_full_q, ab_full_d;
	logic [4:0]             ab_retry_q [NUM_ENTRIES];
	logic [4:0]             ab_retry_d [NUM_ENTRIES];
	logic [7:0]             ab_byte_q [NUM_ENTRIES];
	logic [7:0]             ab_byte_d [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] c_in_q, c_in_d;
	logic [3:0]             c_nib_q [NUM_ENTRIES];
	logic [3:0]             c_nib_d [NUM_ENTRIES];
	logic [1:0]             c_phase_q, c_phase_d;

	// Decode helpers
	logic [1:0] own, opp, c_hi, c_lo, p_hi, p_lo, ci, cpart;
	logic       psd, half;
	logic [3:0] bit_mask;
	logic [3:0] rd_hi, rd_lo;

	// Repeated-access policy
	logic [4:0] retry_dec;
	logic       rep_go, rep_tog, rep_stop, rep_wake;
	logic [4:0] rep_retry;

	// Port C write policy
	logic       cw_tog, cw_mdor, cw_sdor;
	logic [1:0] cw_both;

	// Result of the access
	logic [7:0] rd;
	logic       tog, stop, mdor, sdor, mis;
	logic [1:0] both;

	assign psd   = ~side_q;
	assign own   = {side_q, port_q};
	assign opp   = {psd, ~port_q};
	assign c_hi  = {side_q, HALF_HI};
	assign c_lo  = {side_q, HALF_LO};
	assign p_hi  = {psd, HALF_HI};
	assign p_lo  = {psd, HALF_LO};
	assign half  = wdata_q[3] ? HALF_HI : HALF_LO;
	assign ci    = {side_q, half};
	assign cpart = {psd, ~half};
	assign bit_mask = 4'b0001 << wdata_q[2:1];
	assign rd_hi = c_in_q[c_hi] ? c_nib_q[p_lo] : c_nib_q[c_hi];
	assign rd_lo = c_in_q[c_lo] ? c_nib_q[p_hi] : c_nib_q[c_lo];
	assign retry_dec = ab_retry_q[own] - 5'd1;

	// Decide whether a repeated A/B access waits or goes ahead
	always_comb begin
		rep_go    = 1'b1;
		rep_tog   = 1'b0;
		rep_stop  = 1'b0;
		rep_wake  = 1'b0;
		rep_retry = RETRY_RLD;
		case (policy_q)
			POL_WAKE: begin
				rep_wake = 1'b1;
			end
			POL_PLAIN, POL_BOTH: begin
				rep_go = 1'b1;
			end
			POL_WAIT: begin
				if (retry_dec != 5'd0) begin
					rep_go    = 1'b0;
					rep_stop  = 1'b1;
					rep_retry = retry_dec;
				end
			end
			default: begin
				if (retry_dec != 5'd0) begin
					rep_go    = 1'b0;
					rep_tog   = 1'b1;
					rep_stop  = 1'b1;
					rep_retry = retry_dec;
				end
			end
		endcase
	end

	// Pick scheduler actions for a port C write
	always_comb begin
		cw_tog  = 1'b0;
		cw_mdor = 1'b0;
		cw_sdor = 1'b0;
		cw_both = BOTH_NONE;
		case (policy_q)
			POL_PLAIN, POL_BOTH, POL_WAIT: begin
				cw_tog = 1'b0;
			end
			POL_WAKE: begin
				if (!side_q) begin
					cw_both = BOTH_STD;
					cw_mdor = 1'b1;
				end
			end
			default: begin
				cw_tog = 1'b1;
				if (!side_q) begin
					cw_both = BOTH_ONE;
					cw_mdor = 1'b1;
				end else begin
					cw_sdor = 1'b1;
				end
			end
		endcase
	end

	// Run the access: next port state and result fields
	always_comb begin
		ab_in_d   = ab_in_q;
		ab_full_d = ab_full_q;
		ab_retry_d = ab_retry_q;
		ab_byte_d = ab_byte_q;
		c_in_d    = c_in_q;
		c_nib_d   = c_nib_q;
		c_phase_d = c_phase_q;
		rd   = 8'd0;
		tog  = 1'b0;
		stop = 1'b0;
		mdor = 1'b0;
		sdor = 1'b0;
		both = BOTH_NONE;
		mis  = 1'b0;
		case (mode_q)
			MODE_RD_AB: begin
				mis = ab_in_q[opp] || !ab_in_q[own];
				if (!ab_in_q[own]) begin
					// Output port reads back its own byte
					ab_retry_d[own] = RETRY_RLD;
					rd = ab_byte_q[own];
				end else begin
					if (ab_full_q[opp]) begin
						ab_full_d[opp]  = 1'b0;
						ab_retry_d[own] = RETRY_RLD;
					end else begin
						ab_retry_d[own] = rep_retry;
						tog  = rep_tog;
						stop = rep_stop;
						if (rep_wake && !side_q) begin
							both = BOTH_STD;
							mdor = 1'b1;
						end
					end
					rd = ab_byte_q[opp];
				end
			end
			MODE_WR_AB: begin
				mis = !ab_in_q[opp] || ab_in_q[own];
				if (!ab_full_q[own]) begin
					ab_full_d[own]  = 1'b1;
					ab_byte_d[own]  = wdata_q;
					ab_retry_d[own] = RETRY_RLD;
				end else begin
					ab_retry_d[own] = rep_retry;
					tog  = rep_tog;
					stop = rep_stop;
					if (rep_wake && !side_q) begin
						both = BOTH_STD;
						mdor = 1'b1;
					end
					if (rep_go) begin
						ab_byte_d[own] = wdata_q;
					end
				end
			end
			MODE_RD_C: begin
				mis = (c_in_q[p_hi] && c_in_q[p_lo]) || (!c_in_q[c_hi] && !c_in_q[c_lo]);
				rd = {rd_hi, rd_lo};
				c_phase_d[side_q] = ~c_phase_q[side_q];
				// Act on every second read
				if (c_phase_q[side_q]) begin
					if (policy_q == POL_WAKE) begin
						if (!side_q) begin
							both = BOTH_STD;
							mdor = 1'b1;
						end
					end else if (policy_q != POL_BOTH && policy_q != POL_WAIT) begin
						tog  = 1'b1;
						stop = 1'b1;
					end
				end
			end
			MODE_BIT_C: begin
				mis = !c_in_q[cpart] || c_in_q[ci];
				if (wdata_q[0]) begin
					c_nib_d[ci] = c_nib_q[ci] | bit_mask;
				end else begin
					c_nib_d[ci] = c_nib_q[ci] & ~bit_mask;
				end
				tog  = cw_tog;
				mdor = cw_mdor;
				sdor = cw_sdor;
				both = cw_both;
			end
			MODE_WR_C: begin
				mis = (!c_in_q[p_hi] && !c_in_q[p_lo]) || (c_in_q[c_hi] && c_in_q[c_lo]);
				c_nib_d[c_hi] = wdata_q[7:4];
				c_nib_d[c_lo] = wdata_q[3:0];
				tog  = cw_tog;
				mdor = cw_mdor;
				sdor = cw_sdor;
				both = cw_both;
			end
			MODE_SET: begin
				ab_in_d[{side_q, 1'b0}]    = wdata_q[4];
				ab_in_d[{side_q, 1'b1}]    = wdata_q[1];
				c_in_d[c_hi]               = wdata_q[3];
				c_in_d[c_lo]               = wdata_q[0];
				ab_byte_d[{side_q, 1'b0}]  = 8'd0;
				ab_byte_d[{side_q, 1'b1}]  = 8'd0;
				ab_full_d[{side_q, 1'b0}]  = 1'b0;
				ab_full_d[{side_q, 1'b1}]  = 1'b0;
				ab_retry_d[{side_q, 1'b0}] = RETRY_RLD;
				ab_retry_d[{side_q, 1'b1}] = RETRY_RLD;
				c_nib_d[c_hi]              = 4'd0;
				c_nib_d[c_lo]              = 4'd0;
				c_phase_d[side_q]          = 1'b1;
			end
			default: begin
				mis = 1'b0;
			end
		endcase
	end

	// Hold the policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_PLAIN;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	// Capture the access word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			side_q  <= side;
			port_q  <= port_sel;
			wdata_q <= wdata;
		end
	end

	// Advance port state when the access runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ab_in_q   <= AB_IN_RST;
			ab_full_q <= '0;
			c_in_q    <= C_IN_RST;
			c_phase_q <= 2'b11;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				ab_retry_q[i] <= RETRY_RLD;
				ab_byte_q[i]  <= 8'd0;
				c_nib_q[i]    <= 4'd0;
			end
		end else if (cmd.exec) begin
			ab_in_q    <= ab_in_d;
			ab_full_q  <= ab_full_d;
			c_in_q     <= c_in_d;
			c_phase_q  <= c_phase_d;
			ab_retry_q <= ab_retry_d;
			ab_byte_q  <= ab_byte_d;
			c_nib_q    <= c_nib_d;
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			read_data     <= rd;
			toggle_cpu    <= tog;
			stop_running  <= stop;
			main_dormant  <= mdor;
			sub_dormant   <= sdor;
			run_both_code <= both;
			mismatch      <= mis;
		end
	end

endmodule

[hdl/cross_linked_dual_parallel_port.sv]
// ----------------------------------------------------------------------------
// cross_linked_dual_parallel_port
// A result word is registered when its access runs, once the result slot is free.
// The capture/run sequencer takes no new access word until the last one has run.
// A stalled result word blocks the next access until it is taken.
// Reset (arst_n low) clears the policy, returns port directions to their reset values, and clears flags and bytes.
// ----------------------------------------------------------------------------
module cross_linked_dual_parallel_port
	import clpp_pkg::*;
#(
	parameter int RETRY_COUNT = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	clpp_req_if.sink          req,
	clpp_rsp_if.source        rsp,
	input  logic              cfg_we,
	input  logic signed [2:0] cfg_wdata
);

	clpp_cmd_t cmd;

	// Sequence access words
	clpp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// Hold port state and run accesses
	clpp_dp #(
		.RETRY_COUNT (RETRY_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.mode          (req.mode),
		.side          (req.side),
		.port_sel      (req.port_sel),
		.wdata         (req.wdata),
		.read_data     (rsp.read_data),
		.toggle_cpu    (rsp.toggle_cpu),
		.stop_running  (rsp.stop_running),
		.main_dormant  (rsp.main_dormant),
		.sub_dormant   (rsp.sub_dormant),
		.run_both_code (rsp.run_both_code),
		.mismatch      (rsp.mismatch)
	);

endmodule

[tb/cross_linked_dual_parallel_port_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_linked_dual_parallel_port_tb
// Drives random and directed bus accesses into both processor sides of the
// port pair, with random gaps and stalls on both channels. A behavioral copy
// of the two units predicts each reply word, which is compared field by
// field against the block's output. Runs through every switching policy.
// ----------------------------------------------------------------------------
module cross_linked_dual_parallel_port_tb;
	import clpp_pkg::*;

	localparam int RETRY_COUNT = 16;
	localparam logic [4:0] RETRY_RELOAD = 5'(RETRY_COUNT);
	localparam int PHASE_ITEMS = 230;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 10;
	localparam int REPORT_MAX = 10;
	localparam longint LIMIT_NS = 64'd12_000_000;

	// Codes the package leaves out
	localparam logic [2:0] MODE_RSV6 = 3'd6;
	localparam logic [2:0] MODE_RSV7 = 3'd7;
	localparam logic signed [2:0] POL_SWITCH    = -3'sd1;
	localparam logic signed [2:0] POL_SWITCH_N2 = -3'sd2;
	localparam logic signed [2:0] POL_SWITCH_N3 = -3'sd3;
	localparam logic signed [2:0] POL_SWITCH_N4 = -3'sd4;
	localparam logic PORT_A = 1'b0;
	localparam logic PORT_B = 1'b1;

	typedef struct packed {
		logic [2:0] mode;
		logic       side;
		logic       port_sel;
		logic [7:0] wdata;
	} port_access_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       toggle_cpu;
		logic       stop_running;
		logic       main_dormant;
		logic       sub_dormant;
		logic [1:0] run_both_code;
		logic       mismatch;
	} port_reply_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic signed [2:0] cfg_wdata;

	clpp_req_if req_ch();
	clpp_rsp_if rsp_ch();

	cross_linked_dual_parallel_port #(
		.RETRY_COUNT(RETRY_COUNT)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predicted state of both units
	logic signed [2:0] policy_q;
	logic [3:0] ab_in, ab_full, c_in;
	logic [4:0] ab_retry [4];
	logic [7:0] ab_byte [4];
	logic [3:0] c_nib [4];
	logic [1:0] c_phase;

	port_access_t access_q [$];
	port_reply_t  reply_q [$];
	port_access_t cur_access;
	port_reply_t  want_reply, got_reply, next_reply;
	logic         word_loaded;
	int           send_gap, take_gap;
	int           accepted_cnt;
	int           fail_cnt;
	logic         rsp_hold = 1'b0;
	logic         steady = 1'b0;

	task automatic reset_port_model();
		policy_q = POL_PLAIN;
		ab_in = AB_IN_RST;
		c_in = C_IN_RST;
		ab_full = '0;
		c_phase = 2'b11;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			ab_retry[i] = RETRY_RELOAD;
			ab_byte[i] = '0;
			c_nib[i] = '0;
		end
	endtask

	// Only the main side wakes its partner
	task automatic wake_partner(input logic side, inout port_reply_t r);
		if (!side) begin
			r.run_both_code = BOTH_STD;
			r.main_dormant = 1'b1;
		end
	endtask

	// Policy for a read with nothing new or a write to a full port
	task automatic repeat_access(input logic side, input logic [1:0] idx,
			inout port_reply_t r, output logic go);
		go = 1'b1;
		case (policy_q)
			POL_WAKE: begin
				wake_partner(side, r);
				ab_retry[idx] = RETRY_RELOAD;
			end
			POL_PLAIN, POL_BOTH: ab_retry[idx] = RETRY_RELOAD;
			default: begin
				ab_retry[idx] = ab_retry[idx] - 5'd1;
				if (ab_retry[idx] != 5'd0) begin
					go = 1'b0;
					r.stop_running = 1'b1;
					if (policy_q != POL_WAIT)
						r.toggle_cpu = 1'b1;
				end else begin
					ab_retry[idx] = RETRY_RELOAD;
				end
			end
		endcase
	endtask

	task automatic c_write_actions(input logic side, inout port_reply_t r);
		case (policy_q)
			POL_PLAIN, POL_BOTH, POL_WAIT: ;
			POL_WAKE: wake_partner(side, r);
			default: begin
				r.toggle_cpu = 1'b1;
				if (!side) begin
					r.run_both_code = BOTH_ONE;
					r.main_dormant = 1'b1;
				end else begin
					r.sub_dormant = 1'b1;
				end
			end
		endcase
	endtask

	// Apply one access to the predicted state and form its reply word
	task automatic compute_port_reply(input port_access_t a, output port_reply_t r);
		logic       psd, half, go;
		logic [1:0] own, opp, ci;
		logic [3:0] hi, lo, bitm;
		psd = ~a.side;
		own = {a.side, a.port_sel};
		opp = {psd, ~a.port_sel};
		r = '0;
		case (a.mode)
			MODE_RD_AB: begin
				r.mismatch = ab_in[opp] | ~ab_in[own];
				if (!ab_in[own]) begin
					// output port reads back its own byte
					ab_retry[own] = RETRY_RELOAD;
					r.read_data = ab_byte[own];
				end else begin
					if (ab_full[opp]) begin
						ab_full[opp] = 1'b0;
						ab_retry[own] = RETRY_RELOAD;
					end else begin
						repeat_access(a.side, own, r, go);
					end
					r.read_data = ab_byte[opp];
				end
			end
			MODE_WR_AB: begin
				r.mismatch = ~ab_in[opp] | ab_in[own];
				if (!ab_full[own]) begin
					ab_full[own] = 1'b1;
					ab_byte[own] = a.wdata;
					ab_retry[own] = RETRY_RELOAD;
				end else begin
					repeat_access(a.side, own, r, go);
					if (go)
						ab_byte[own] = a.wdata;
				end
			end
			MODE_RD_C: begin
				r.mismatch = (c_in[{psd, HALF_HI}] & c_in[{psd, HALF_LO}])
					| (~c_in[{a.side, HALF_HI}] & ~c_in[{a.side, HALF_LO}]);
				hi = c_in[{a.side, HALF_HI}] ? c_nib[{psd, HALF_LO}] : c_nib[{a.side, HALF_HI}];
				lo = c_in[{a.side, HALF_LO}] ? c_nib[{psd, HALF_HI}] : c_nib[{a.side, HALF_LO}];
				r.read_data = {hi, lo};
				c_phase[a.side] = ~c_phase[a.side];
				if (!c_phase[a.side]) begin
					if (policy_q == POL_WAKE) begin
						wake_partner(a.side, r);
					end else if (policy_q != POL_BOTH && policy_q != POL_WAIT) begin
						r.toggle_cpu = 1'b1;
						r.stop_running = 1'b1;
					end
				end
			end
			MODE_BIT_C: begin
				half = a.wdata[3] ? HALF_HI : HALF_LO;
				ci = {a.side, half};
				bitm = 4'b0001 << a.wdata[2:1];
				r.mismatch = ~c_in[{psd, ~half}] | c_in[ci];
				if (a.wdata[0])
					c_nib[ci] = c_nib[ci] | bitm;
				else
					c_nib[ci] = c_nib[ci] & ~bitm;
				c_write_actions(a.side, r);
			end
			MODE_WR_C: begin
				r.mismatch = (~c_in[{psd, HALF_HI}] & ~c_in[{psd, HALF_LO}])
					| (c_in[{a.side, HALF_HI}] & c_in[{a.side, HALF_LO}]);
				c_nib[{a.side, HALF_HI}] = a.wdata[7:4];
				c_nib[{a.side, HALF_LO}] = a.wdata[3:0];
				c_write_actions(a.side, r);
			end
			MODE_SET: begin
				ab_in[{a.side, PORT_A}] = a.wdata[4];
				ab_in[{a.side, PORT_B}] = a.wdata[1];
				c_in[{a.side, HALF_HI}] = a.wdata[3];
				c_in[{a.side, HALF_LO}] = a.wdata[0];
				ab_byte[{a.side, PORT_A}] = '0;
				ab_byte[{a.side, PORT_B}] = '0;
				ab_full[{a.side, PORT_A}] = 1'b0;
				ab_full[{a.side, PORT_B}] = 1'b0;
				ab_retry[{a.side, PORT_A}] = RETRY_RELOAD;
				ab_retry[{a.side, PORT_B}] = RETRY_RELOAD;
				c_nib[{a.side, HALF_HI}] = '0;
				c_nib[{a.side, HALF_LO}] = '0;
				c_phase[a.side] = 1'b1;
			end
			default: ;
		endcase
	endtask

	// Gap length: mostly short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	function automatic logic [2:0] pick_mode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return MODE_RD_AB;
		if (r < 40) return MODE_WR_AB;
		if (r < 55) return MODE_RD_C;
		if (r < 70) return MODE_BIT_C;
		if (r < 82) return MODE_WR_C;
		if (r < 92) return MODE_SET;
		if (r < 96) return MODE_RSV6;
		return MODE_RSV7;
	endfunction

	task automatic queue_access(input logic [2:0] mode, input logic side,
			input logic port_sel, input logic [7:0] wdata);
		port_access_t a;
		a.mode = mode;
		a.side = side;
		a.port_sel = port_sel;
		a.wdata = wdata;
		access_q.push_back(a);
	endtask

	// Mix of cross transfers, repeated-access bursts and single accesses
	task automatic queue_random_accesses(input int target);
		port_access_t a;
		int done, kind, reps;
		done = 0;
		while (done < target) begin
			kind = $urandom_range(0, 9);
			a.mode = pick_mode();
			a.side = 1'($urandom_range(0, 1));
			a.port_sel = 1'($urandom_range(0, 1));
			a.wdata = 8'($urandom);
			if (kind < 3) begin
				queue_access(MODE_WR_AB, a.side, a.port_sel, a.wdata);
				queue_access(MODE_RD_AB, ~a.side, ~a.port_sel, 8'($urandom));
				done += 2;
			end else begin
				reps = (kind < 5) ? $urandom_range(2, 40) : 1;
				repeat (reps) access_q.push_back(a);
				if (a.mode != MODE_RSV6 && a.mode != MODE_RSV7)
					done += reps;
			end
		end
	endtask

	// Wait until every queued word has been sent and answered
	task automatic wait_drained();
		do
			@(negedge clk);
		while (access_q.size() != 0 || req_ch.valid || reply_q.size() != 0);
	endtask

	task automatic write_policy(input logic signed [2:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		policy_q = value;
	endtask

	// Access driver: hold each word until taken, then predict its reply
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.mode <= '0;
			req_ch.side <= 1'b0;
			req_ch.port_sel <= 1'b0;
			req_ch.wdata <= '0;
			word_loaded = 1'b0;
			send_gap = 0;
			accepted_cnt = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				compute_port_reply(cur_access, next_reply);
				reply_q.push_back(next_reply);
				accepted_cnt++;
				word_loaded = 1'b0;
				send_gap = (steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
			end
			if (!word_loaded) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (access_q.size() != 0) begin
					cur_access = access_q.pop_front();
					word_loaded = 1'b1;
				end
			end
			req_ch.valid <= word_loaded;
			req_ch.mode <= cur_access.mode;
			req_ch.side <= cur_access.side;
			req_ch.port_sel <= cur_access.port_sel;
			req_ch.wdata <= cur_access.wdata;
		end
	end

	// Reply monitor: check each taken word, then stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			take_gap = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_reply.read_data = rsp_ch.read_data;
				got_reply.toggle_cpu = rsp_ch.toggle_cpu;
				got_reply.stop_running = rsp_ch.stop_running;
				got_reply.main_dormant = rsp_ch.main_dormant;
				got_reply.sub_dormant = rsp_ch.sub_dormant;
				got_reply.run_both_code = rsp_ch.run_both_code;
				got_reply.mismatch = rsp_ch.mismatch;
				if (reply_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_MAX)
						$display("%0t: reply word with none pending", $realtime);
				end else begin
					want_reply = reply_q.pop_front();
					if (got_reply.read_data !== want_reply.read_data
						|| got_reply.toggle_cpu !== want_reply.toggle_cpu
						|| got_reply.stop_running !== want_reply.stop_running
						|| got_reply.main_dormant !== want_reply.main_dormant
						|| got_reply.sub_dormant !== want_reply.sub_dormant
						|| got_reply.run_both_code !== want_reply.run_both_code
						|| got_reply.mismatch !== want_reply.mismatch) begin
						fail_cnt++;
						if (fail_cnt <= REPORT_MAX) begin
							$display("%0t: exp rd=%h tog=%b stop=%b mdor=%b sdor=%b both=%0d mis=%b",
								$realtime, want_reply.read_data, want_reply.toggle_cpu,
								want_reply.stop_running, want_reply.main_dormant,
								want_reply.sub_dormant, want_reply.run_both_code,
								want_reply.mismatch);
							$display("%0t: got rd=%h tog=%b stop=%b mdor=%b sdor=%b both=%0d mis=%b",
								$realtime, got_reply.read_data,
								got_reply.toggle_cpu, got_reply.stop_running,
								got_reply.main_dormant, got_reply.sub_dormant,
								got_reply.run_both_code, got_reply.mismatch);
						end
					end
				end
			end
			if (take_gap > 0)
				take_gap--;
			else if (!steady && $urandom_range(0, 4) == 0)
				take_gap = idle_len();
			rsp_ch.ready <= !rsp_hold && take_gap == 0;
		end
	end

	// Alternate stretches of random idling and stretches without any
	initial begin
		forever begin
			repeat ($urandom_range(100, 400)) @(posedge clk);
			steady <= ~steady;
		end
	end

	// Hold off replies long enough to back the block up into its input
	initial begin
		while (accepted_cnt < 100) @(posedge clk);
		rsp_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	initial begin
		#(LIMIT_NS);
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic signed [2:0] policy_plan [9];
		policy_plan = '{POL_PLAIN, POL_WAIT, POL_SWITCH, POL_WAKE, POL_BOTH,
			POL_SWITCH_N4, POL_WAIT, POL_SWITCH_N2, POL_SWITCH_N3};
		fail_cnt = 0;
		cur_access = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= POL_PLAIN;
		reset_port_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed accesses under the reset policy
		queue_access(MODE_RD_AB, 1'b0, PORT_A, 8'h00);
		queue_access(MODE_RD_AB, 1'b0, PORT_B, 8'hff);
		queue_access(MODE_WR_AB, 1'b1, PORT_B, 8'hff);
		queue_access(MODE_WR_AB, 1'b1, PORT_B, 8'h00);
		queue_access(MODE_RD_AB, 1'b0, PORT_A, 8'h00);
		queue_access(MODE_WR_AB, 1'b0, PORT_A, 8'h5a);
		queue_access(MODE_RD_C, 1'b0, PORT_A, 8'h00);
		queue_access(MODE_RD_C, 1'b0, PORT_B, 8'h00);
		queue_access(MODE_BIT_C, 1'b0, PORT_A, 8'h0f);
		queue_access(MODE_BIT_C, 1'b0, PORT_A, 8'h00);
		queue_access(MODE_BIT_C, 1'b1, PORT_B, 8'hf7);
		queue_access(MODE_WR_C, 1'b1, PORT_A, 8'hff);
		queue_access(MODE_RD_C, 1'b0, PORT_A, 8'h00);
		queue_access(MODE_WR_C, 1'b0, PORT_B, 8'h00);
		queue_access(MODE_SET, 1'b0, PORT_A, 8'hff);
		queue_access(MODE_RD_AB, 1'b1, PORT_A, 8'h00);
		queue_access(MODE_SET, 1'b1, PORT_B, 8'h00);
		queue_access(MODE_WR_AB, 1'b1, PORT_A, 8'h80);
		queue_access(MODE_RD_AB, 1'b0, PORT_B, 8'h00);
		queue_access(MODE_SET, 1'b0, PORT_A, 8'h1b);
		queue_access(MODE_RSV6, 1'b1, PORT_B, 8'hff);
		queue_access(MODE_RSV7, 1'b0, PORT_A, 8'h00);
		queue_access(MODE_RD_AB, 1'b1, PORT_B, 8'hff);

		// One random phase per policy setting
		foreach (policy_plan[p]) begin
			wait_drained();
			write_policy(policy_plan[p]);
			queue_random_accesses(PHASE_ITEMS);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && reply_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
